// ===== rtl/hdwm_pkg.sv =====
// ----------------------------------------------------------------------------
// hdwm_pkg
// Types, constants and helper functions shared by the wheel mixer modules.
// ----------------------------------------------------------------------------
package hdwm_pkg;

  localparam int AccW  = 56;
  localparam int MulAW = 34;
  localparam int MulBW = 18;
  localparam int MulPW = MulAW + MulBW;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_STOP = 2'd1,
    CMD_SET  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    REG_DRIVE_MODE  = 3'd0,
    REG_BASE_TYPE   = 3'd1,
    REG_FACING      = 3'd2,
    REG_SPEED_SCALE = 3'd3,
    REG_TURN_RATIO  = 3'd4,
    REG_HEAD_TOL    = 3'd5,
    REG_HEAD_GAIN   = 3'd6
  } reg_e;

  localparam logic [1:0] ModeRobot = 2'd0;
  localparam logic [1:0] ModeField = 2'd1;
  localparam logic [1:0] ModeHold  = 2'd2;
  localparam logic [1:0] ModeBad   = 2'd3;

  localparam logic [1:0] BaseOmni4 = 2'd0;
  localparam logic [1:0] BaseMec   = 2'd1;
  localparam logic [1:0] BaseOmni3 = 2'd2;
  localparam logic [1:0] BaseBad   = 2'd3;

  localparam logic [1:0] FaceNormal = 2'd0;
  localparam logic [1:0] FaceCw     = 2'd1;
  localparam logic [1:0] FaceBack   = 2'd2;
  localparam logic [1:0] FaceCcw    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_SC, S_SCW, S_CHECK, S_CORR, S_CORRW, S_PLAN,
    S_TRIG, S_TWAIT, S_MAC, S_MACW, S_OUT
  } state_e;

  typedef enum logic [2:0] {
    K_OMNI4_R, K_MEC_R, K_OMNI3_R, K_OMNI4_F, K_OMNI3_F
  } kind_e;

  typedef enum logic [1:0] { A_XV, A_YV, A_WV } asel_e;
  typedef enum logic [1:0] { B_CONST, B_TR2, B_COS, B_SIN } bsel_e;

  typedef struct packed {
    logic                    trig;
    logic [15:0]             ang;
    asel_e                   asel;
    bsel_e                   bsel;
    logic signed [MulBW-1:0] bconst;
    logic [3:0]              add;
    logic [3:0]              sub;
    logic                    last;
  } mac_op_t;

  function automatic mac_op_t mk(logic trig, logic [15:0] ang, asel_e asel, bsel_e bsel,
                                 logic signed [MulBW-1:0] bc, logic [3:0] add,
                                 logic [3:0] sub, logic last);
    mac_op_t o;
    o.trig = trig; o.ang = ang; o.asel = asel; o.bsel = bsel; o.bconst = bc;
    o.add = add; o.sub = sub; o.last = last;
    return o;
  endfunction

  // per-base multiply-accumulate program, bit i of add/sub is wheel i+1
  function automatic mac_op_t get_op(kind_e kind, logic [2:0] step);
    mac_op_t o;
    o = mk(1'b0, 16'd0, A_XV, B_CONST, 18'sd0, 4'b0000, 4'b0000, 1'b1);
    unique case (kind)
      K_OMNI4_R: begin
        unique case (step)
          3'd0: o = mk(1'b0, 16'd0, A_XV, B_CONST, 18'sd23170, 4'b1001, 4'b0110, 1'b0);
          3'd1: o = mk(1'b0, 16'd0, A_YV, B_CONST, 18'sd23170, 4'b1111, 4'b0000, 1'b0);
          default: o = mk(1'b0, 16'd0, A_WV, B_TR2, 18'sd0, 4'b0101, 4'b1010, 1'b1);
        endcase
      end
      K_MEC_R: begin
        unique case (step)
          3'd0: o = mk(1'b0, 16'd0, A_XV, B_CONST, 18'sd32768, 4'b1001, 4'b0110, 1'b0);
          3'd1: o = mk(1'b0, 16'd0, A_YV, B_CONST, 18'sd32768, 4'b1111, 4'b0000, 1'b0);
          default: o = mk(1'b0, 16'd0, A_WV, B_CONST, 18'sd32768, 4'b0101, 4'b1010, 1'b1);
        endcase
      end
      K_OMNI3_R: begin
        unique case (step)
          3'd0: o = mk(1'b0, 16'd0, A_XV, B_CONST, 18'sd32768, 4'b0100, 4'b0000, 1'b0);
          3'd1: o = mk(1'b0, 16'd0, A_YV, B_CONST, 18'sd28378, 4'b0011, 4'b0000, 1'b0);
          3'd2: o = mk(1'b0, 16'd0, A_XV, B_CONST, 18'sd16384, 4'b0010, 4'b0001, 1'b0);
          default: o = mk(1'b0, 16'd0, A_WV, B_TR2, 18'sd0, 4'b0101, 4'b0010, 1'b1);
        endcase
      end
      K_OMNI4_F: begin
        unique case (step)
          3'd0: o = mk(1'b1, 16'd8192, A_XV, B_COS, 18'sd0, 4'b1001, 4'b0000, 1'b0);
          3'd1: o = mk(1'b0, 16'd0, A_YV, B_SIN, 18'sd0, 4'b1001, 4'b0000, 1'b0);
          3'd2: o = mk(1'b1, 16'd24576, A_XV, B_COS, 18'sd0, 4'b0110, 4'b0000, 1'b0);
          3'd3: o = mk(1'b0, 16'd0, A_YV, B_SIN, 18'sd0, 4'b0110, 4'b0000, 1'b0);
          default: o = mk(1'b0, 16'd0, A_WV, B_TR2, 18'sd0, 4'b0101, 4'b1010, 1'b1);
        endcase
      end
      K_OMNI3_F: begin
        unique case (step)
          3'd0: o = mk(1'b1, 16'd0, A_XV, B_COS, 18'sd0, 4'b0100, 4'b0000, 1'b0);
          3'd1: o = mk(1'b0, 16'd0, A_YV, B_SIN, 18'sd0, 4'b0100, 4'b0000, 1'b0);
          3'd2: o = mk(1'b1, 16'd21845, A_XV, B_COS, 18'sd0, 4'b0001, 4'b0000, 1'b0);
          3'd3: o = mk(1'b0, 16'd0, A_YV, B_SIN, 18'sd0, 4'b0001, 4'b0000, 1'b0);
          3'd4: o = mk(1'b1, 16'd10923, A_XV, B_COS, 18'sd0, 4'b0010, 4'b0000, 1'b0);
          3'd5: o = mk(1'b0, 16'd0, A_YV, B_SIN, 18'sd0, 4'b0010, 4'b0000, 1'b0);
          default: o = mk(1'b0, 16'd0, A_WV, B_TR2, 18'sd0, 4'b0101, 4'b0010, 1'b1);
        endcase
      end
      default: o = mk(1'b0, 16'd0, A_XV, B_CONST, 18'sd0, 4'b0000, 4'b0000, 1'b1);
    endcase
    return o;
  endfunction

  function automatic logic [31:0] atan_at(logic [3:0] i);
    logic [31:0] r;
    unique case (i)
      4'd0:  r = 32'd536870912;
      4'd1:  r = 32'd316933406;
      4'd2:  r = 32'd167458907;
      4'd3:  r = 32'd85004756;
      4'd4:  r = 32'd42667331;
      4'd5:  r = 32'd21354465;
      4'd6:  r = 32'd10680862;
      4'd7:  r = 32'd5340245;
      4'd8:  r = 32'd2670163;
      4'd9:  r = 32'd1335087;
      4'd10: r = 32'd667544;
      4'd11: r = 32'd333772;
      4'd12: r = 32'd166886;
      4'd13: r = 32'd83443;
      4'd14: r = 32'd41722;
      default: r = 32'd20861;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [AccW-1:0] v);
    logic signed [15:0] r;
    if (v > 56'sd32767) r = 16'sh7FFF;
    else if (v < -56'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ===== rtl/hdwm_mul.sv =====
// ----------------------------------------------------------------------------
// hdwm_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module hdwm_mul (
  input  logic                                  clk_i,
  input  logic signed [hdwm_pkg::MulAW-1:0]     a_i,
  input  logic signed [hdwm_pkg::MulBW-1:0]     b_i,
  output logic signed [hdwm_pkg::MulPW-1:0]     p_o
);
  import hdwm_pkg::*;

  logic signed [MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== rtl/hdwm_cordic.sv =====
// ----------------------------------------------------------------------------
// hdwm_cordic
// Sixteen-step rotation CORDIC, one step a cycle, giving cos and sin in Q2.15.
// ----------------------------------------------------------------------------
module hdwm_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [15:0]        angle_i,
  output logic               done_o,
  output logic signed [16:0] cos_o,
  output logic signed [16:0] sin_o
);
  import hdwm_pkg::*;

  logic signed [32:0] x_q, y_q, z_q;
  logic [1:0]         quad_q;
  logic [3:0]         iter_q;
  logic               busy_q, done_q;
  logic signed [32:0] dx, dy, at, xr, yr;
  logic signed [16:0] cc, ss;

  always_comb begin
    dx = y_q >>> iter_q;
    dy = x_q >>> iter_q;
    at = 33'(atan_at(iter_q));
    xr = (x_q + 33'sd16384) >>> 15;
    yr = (y_q + 33'sd16384) >>> 15;
    cc = xr[16:0];
    ss = yr[16:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + 4'd1;
        if (iter_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= 33'sd652032874;
      y_q    <= '0;
      z_q    <= $signed({3'b000, angle_i[13:0], 16'd0});
      quad_q <= angle_i[15:14];
    end else if (busy_q) begin
      if (!z_q[32]) begin
        x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
      end
    end
  end

  always_comb begin
    unique case (quad_q)
      2'd0: begin cos_o = cc;  sin_o = ss;  end
      2'd1: begin cos_o = -ss; sin_o = cc;  end
      2'd2: begin cos_o = -cc; sin_o = -ss; end
      default: begin cos_o = ss; sin_o = -cc; end
    endcase
  end

  assign done_o = done_q;

endmodule

// ===== rtl/holonomic_drive_wheel_mixer.sv =====
// ----------------------------------------------------------------------------
// holonomic_drive_wheel_mixer
// Joystick to wheel speed mixer for omni and mecanum bases.
// ----------------------------------------------------------------------------
// One item at a time: after an item is taken, a sequencer runs the stick scaling,
// the optional heading correction and the wheel sums through one shared 34x18
// multiplier, and fetches each field angle's sine and cosine from a CORDIC. An
// all-zero command goes straight to a none or stop result, a base that gives
// none skips the wheel sums, and a heading correction in hold mode adds one
// product. The result sits in an output register, so the next item is taken
// while it waits.
module holonomic_drive_wheel_mixer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stick_x[15:0] stick_y[31:16] trigger_right[46:32] trigger_left[61:47]
  // heading[93:62] drive_busy[94]
  input  logic [95:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[1:0] wheel_one[17:2] wheel_two[33:18] wheel_three[49:34]
  // wheel_four[65:50]
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import hdwm_pkg::*;

  // configuration
  logic [1:0]  mode_q, base_q, face_q;
  logic [15:0] spd_q, tr_q, gain_q;
  logic [14:0] tol_q;

  // item and working registers
  logic signed [15:0] sx_q, sy_q;
  logic [14:0]        trr_q, trl_q;
  logic signed [31:0] hd_q;
  logic               busy_q;
  logic signed [32:0] xv_q, yv_q, wv_q, e_q;
  logic [1:0]         sc_q;
  logic [2:0]         step_q;
  kind_e              kind_q;
  cmd_e               cmd_q;
  logic signed [AccW-1:0] acc_q [4];

  // heading hold state
  logic               turning_q;
  logic signed [31:0] target_q;
  logic signed [15:0] corr_q;

  // output register
  logic [71:0] out_q;
  logic        ovalid_q;

  state_e state_q, state_d;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] mul_p;
  logic signed [AccW-1:0]  prod;
  logic        cor_start, cor_done;
  logic signed [16:0] cor_cos, cor_sin;
  logic [1:0]  mode_eff;
  mac_op_t     op, op_next;
  logic        all_zero, s_acc, out_load;
  logic signed [32:0] e_now;
  logic signed [AccW-1:0] fbv, cr;
  logic signed [16:0] jx, jy;
  logic signed [15:0] tw;

  hdwm_mul u_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .p_o(mul_p));

  hdwm_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cor_start), .angle_i(op.ang - hd_q[15:0]),
    .done_o(cor_done), .cos_o(cor_cos), .sin_o(cor_sin)
  );

  assign mode_eff = (mode_q == ModeBad) ? ModeRobot : mode_q;
  assign op       = get_op(kind_q, step_q);
  assign op_next  = get_op(kind_q, step_q + 3'd1);
  assign prod     = AccW'(mul_p);
  assign all_zero = (xv_q == '0) && (yv_q == '0) && (wv_q == '0);
  assign e_now    = 33'(hd_q) - 33'(target_q);
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == S_OUT) && (!ovalid_q || m_axis_tready);
  assign fbv      = (mode_eff == ModeHold) ? (AccW'(corr_q) <<< 30) : '0;
  assign cr       = AccW'(mul_p + MulPW'(32768)) >>> 16;

  // operator facing turns the stick in plain field mode only
  always_comb begin
    jx = -17'(sx_q);
    jy = 17'(sy_q);
    if (mode_eff == ModeField) begin
      unique case (face_q)
        FaceCw:   begin jx = 17'(sy_q);  jy = 17'(sx_q);  end
        FaceBack: begin jx = 17'(sx_q);  jy = -17'(sy_q); end
        FaceCcw:  begin jx = -17'(sy_q); jy = -17'(sx_q); end
        default: ;
      endcase
    end
    tw = $signed({1'b0, trr_q}) - $signed({1'b0, trl_q});
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (s_axis_tvalid) state_d = S_SC;
      S_SC:    state_d = S_SCW;
      S_SCW:   state_d = (sc_q == 2'd2) ? S_CHECK : S_SC;
      S_CHECK: begin
        if (all_zero) state_d = S_OUT;
        else if (mode_eff == ModeHold && !turning_q && wv_q == '0 &&
                 (e_now[32] ? -e_now : e_now) >= 33'(tol_q)) state_d = S_CORR;
        else state_d = S_PLAN;
      end
      S_CORR:  state_d = S_CORRW;
      S_CORRW: state_d = S_PLAN;
      S_PLAN: begin
        if (base_q == BaseBad || (base_q == BaseMec && mode_eff != ModeRobot))
          state_d = S_OUT;
        else state_d = S_MAC;
      end
      S_TRIG:  state_d = S_TWAIT;
      S_TWAIT: if (cor_done) state_d = S_MAC;
      S_MAC:   state_d = op.trig && state_q != S_TWAIT ? S_MAC : S_MACW;
      S_MACW: begin
        if (op.last) state_d = S_OUT;
        else if (op_next.trig) state_d = S_TRIG;
        else state_d = S_MAC;
      end
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    // every field program opens with an angle, fetched before the first product
    if (state_q == S_PLAN && state_d == S_MAC && mode_eff != ModeRobot) state_d = S_TRIG;
    if (state_q == S_MAC) state_d = S_MACW;
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    cor_start     = (state_q == S_TRIG);
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SC: begin
        unique case (sc_q)
          2'd0:    mul_a = MulAW'(jx);
          2'd1:    mul_a = MulAW'(jy);
          default: mul_a = MulAW'(tw);
        endcase
        mul_b = $signed({2'b00, spd_q});
      end
      S_CORR: begin
        mul_a = MulAW'(e_q);
        mul_b = $signed({2'b00, gain_q});
      end
      S_MAC: begin
        unique case (op.asel)
          A_XV:    mul_a = MulAW'(xv_q);
          A_YV:    mul_a = MulAW'(yv_q);
          default: mul_a = MulAW'(wv_q);
        endcase
        unique case (op.bsel)
          B_CONST: mul_b = op.bconst;
          B_TR2:   mul_b = $signed({1'b0, tr_q, 1'b0});
          B_COS:   mul_b = MulBW'(cor_cos);
          default: mul_b = MulBW'(cor_sin);
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mode_q    <= ModeRobot;
      base_q    <= BaseOmni4;
      face_q    <= FaceNormal;
      spd_q     <= 16'd768;
      tr_q      <= 16'd8192;
      tol_q     <= 15'd364;
      gain_q    <= 16'd13834;
      turning_q <= 1'b0;
      target_q  <= '0;
      corr_q    <= '0;
      ovalid_q  <= 1'b0;
      sc_q      <= '0;
      step_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_DRIVE_MODE:  mode_q <= cfg_data_i[1:0];
          REG_BASE_TYPE:   base_q <= cfg_data_i[1:0];
          REG_FACING:      face_q <= cfg_data_i[1:0];
          REG_SPEED_SCALE: spd_q  <= cfg_data_i;
          REG_TURN_RATIO:  tr_q   <= cfg_data_i;
          REG_HEAD_TOL:    tol_q  <= cfg_data_i[14:0];
          REG_HEAD_GAIN:   gain_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_acc) sc_q <= '0;
      if (state_q == S_SCW) sc_q <= sc_q + 2'd1;
      if (state_q == S_PLAN) step_q <= '0;
      if (state_q == S_MACW && !op.last) step_q <= step_q + 3'd1;
      // heading hold bookkeeping
      if (state_q == S_CHECK && !all_zero && mode_eff == ModeHold) begin
        if (!turning_q) begin
          if (wv_q != '0) begin
            turning_q <= 1'b1;
            corr_q    <= '0;
          end
        end else if (wv_q == '0) begin
          target_q  <= hd_q;
          turning_q <= 1'b0;
        end else begin
          corr_q <= '0;
        end
      end
      if (state_q == S_CORRW) corr_q <= sat16(cr);
      if (out_load) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      sx_q   <= s_axis_tdata[15:0];
      sy_q   <= s_axis_tdata[31:16];
      trr_q  <= s_axis_tdata[46:32];
      trl_q  <= s_axis_tdata[61:47];
      hd_q   <= s_axis_tdata[93:62];
      busy_q <= s_axis_tdata[94];
    end
    if (state_q == S_SCW) begin
      unique case (sc_q)
        2'd0:    xv_q <= mul_p[32:0];
        2'd1:    yv_q <= mul_p[32:0];
        default: wv_q <= mul_p[32:0];
      endcase
    end
    if (state_q == S_CHECK) begin
      e_q   <= e_now;
      cmd_q <= (mode_eff == ModeField && busy_q) ? CMD_NONE : CMD_STOP;
    end
    if (state_q == S_PLAN) begin
      cmd_q <= CMD_NONE;
      if (mode_eff == ModeRobot) begin
        unique case (base_q)
          BaseOmni4: kind_q <= K_OMNI4_R;
          BaseMec:   kind_q <= K_MEC_R;
          default:   kind_q <= K_OMNI3_R;
        endcase
      end else begin
        kind_q <= (base_q == BaseOmni3) ? K_OMNI3_F : K_OMNI4_F;
      end
      // rounding constant and correction preloaded into the sums
      acc_q[0] <= (AccW'(1) <<< 29) - fbv;
      acc_q[1] <= (AccW'(1) <<< 29) + fbv;
      acc_q[2] <= (AccW'(1) <<< 29) - fbv;
      acc_q[3] <= (base_q == BaseOmni3) ? (AccW'(1) <<< 29) : (AccW'(1) <<< 29) + fbv;
    end
    if (state_q == S_MACW) begin
      for (int i = 0; i < 4; i++) begin
        if (op.add[i]) acc_q[i] <= acc_q[i] + prod;
        else if (op.sub[i]) acc_q[i] <= acc_q[i] - prod;
      end
      if (op.last) cmd_q <= CMD_SET;
    end
    if (out_load) begin
      if (cmd_q == CMD_SET) begin
        out_q <= {6'd0, sat16(acc_q[3] >>> 30), sat16(acc_q[2] >>> 30),
                  sat16(acc_q[1] >>> 30), sat16(acc_q[0] >>> 30), cmd_q};
      end else begin
        out_q <= {70'd0, cmd_q};
      end
    end
  end

  assign m_axis_tdata  = out_q;
  assign m_axis_tvalid = ovalid_q;

  // checks
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("item taken while previous one in flight");

  a_idle_wheels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1:0] != CMD_SET) |-> m_axis_tdata[65:2] == '0)
    else $error("none or stop result with nonzero wheels");

  a_three_wheel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1:0] == CMD_SET && base_q == BaseOmni3)
      |-> m_axis_tdata[65:50] == '0)
    else $error("fourth wheel driven on three-wheel base");

endmodule

// ===== bench/holonomic_drive_wheel_mixer_tb.sv =====
// ----------------------------------------------------------------------------
// holonomic_drive_wheel_mixer_tb
// Stream-level check of the wheel mixer against a cycle-free predictor of the
// mixing, rotation and heading-hold math, over a sweep of register settings,
// with random stalls on both sides.
// ----------------------------------------------------------------------------
module holonomic_drive_wheel_mixer_tb;
  import hdwm_pkg::*;

  localparam int CycleLimit = 800000;
  localparam int DrainWait  = 120;
  localparam int HoldCycles = 400;
  localparam int NumPhases  = 12;
  localparam int RandPerPhase = 82;

  localparam logic [15:0] AngFl4A = 16'd8192;
  localparam logic [15:0] AngFl4B = 16'd24576;
  localparam logic [15:0] AngTh3A = 16'd0;
  localparam logic [15:0] AngTh3B = 16'd21845;
  localparam logic [15:0] AngTh3C = 16'd10923;
  localparam longint CordicGain = 652032874;

  localparam longint ArcTab [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  typedef struct packed {
    logic        busy;
    logic [31:0] hd;
    logic [14:0] tl;
    logic [14:0] tr;
    logic [15:0] sy;
    logic [15:0] sx;
  } sample_t;

  typedef struct packed {
    logic [3:0][15:0] wheel;
    cmd_e             cmd;
  } wheels_t;

  logic        clk_i;
  logic        rst_ni;
  logic [95:0] s_axis_tdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  holonomic_drive_wheel_mixer dut (
    .clk_i, .rst_ni, .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // register copies and hold state
  logic [1:0]  mode_r = ModeRobot;
  logic [1:0]  base_r = BaseOmni4;
  logic [1:0]  face_r = FaceNormal;
  logic [15:0] speed_r = 16'd768;
  logic [15:0] turn_r = 16'd8192;
  logic [14:0] tol_r = 15'd364;
  logic [15:0] gain_r = 16'd13834;
  logic        turning_q = 1'b0;
  longint      target_q = 0;
  longint      corr_q = 0;

  sample_t sample_q[$];
  wheels_t wheel_due_q[$];
  sample_t cur_sample;
  int      errors = 0;
  int      cycles = 0;
  logic    quiet = 1'b0;
  int      hold_req = 0;
  int      hold_seen = 0;
  int      hold_cnt = 0;
  longint  last_hd = 0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint sat_q88(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void cordic_sincos(input logic [15:0] ang, output longint c,
                                        output longint s);
    longint x, y, z, dx, dy, cc, ss;
    x = CordicGain;
    y = 0;
    z = longint'(ang[13:0]) <<< 16;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ArcTab[i];
      end else begin
        x += dx; y -= dy; z += ArcTab[i];
      end
    end
    cc = (x + 16384) >>> 15;
    ss = (y + 16384) >>> 15;
    case (ang[15:14])
      2'd0: begin c = cc; s = ss; end
      2'd1: begin c = -ss; s = cc; end
      2'd2: begin c = -cc; s = -ss; end
      default: begin c = ss; s = -cc; end
    endcase
  endfunction

  function automatic longint project(longint xv, longint yv, logic [15:0] base_ang,
                                     logic [15:0] hdu);
    longint c, s;
    logic [15:0] a;
    a = base_ang - hdu;
    cordic_sincos(a, c, s);
    return xv * c + yv * s;
  endfunction

  function automatic wheels_t mix_sample(sample_t it);
    longint sx, sy, jx, jy, xv, yv, wv, wd, spd, e, ae, a, b;
    longint fb;
    longint v[4];
    logic [1:0] md;
    wheels_t r;
    sx = longint'($signed(it.sx));
    sy = longint'($signed(it.sy));
    spd = longint'(speed_r);
    fb = 0;
    v = '{0, 0, 0, 0};
    r = '0;
    r.cmd = CMD_NONE;
    md = (mode_r == ModeBad) ? ModeRobot : mode_r;
    jx = -sx;
    jy = sy;
    if (md == ModeField) begin
      case (face_r)
        FaceCw:   begin jx = sy;  jy = sx;  end
        FaceBack: begin jx = sx;  jy = -sy; end
        FaceCcw:  begin jx = -sy; jy = -sx; end
        default: ;
      endcase
    end
    xv = jx * spd;
    yv = jy * spd;
    wv = (longint'(it.tr) - longint'(it.tl)) * spd;
    if (xv == 0 && yv == 0 && wv == 0) begin
      r.cmd = (md == ModeField && it.busy) ? CMD_NONE : CMD_STOP;
      return r;
    end
    if (md == ModeHold) begin
      if (!turning_q) begin
        if (wv != 0) begin
          turning_q = 1'b1;
          corr_q = 0;
        end else begin
          e = longint'($signed(it.hd)) - target_q;
          ae = (e < 0) ? -e : e;
          if (ae >= longint'(tol_r))
            corr_q = sat_q88((e * longint'(gain_r) + 32768) >>> 16);
        end
      end else if (wv == 0) begin
        target_q = longint'($signed(it.hd));
        turning_q = 1'b0;
      end else begin
        corr_q = 0;
      end
      fb = corr_q * 64'sd1073741824;
    end
    wd = wv * longint'(turn_r) * 2;
    if (base_r == BaseBad || (base_r == BaseMec && md != ModeRobot)) return r;
    if (md == ModeRobot) begin
      if (base_r == BaseOmni4) begin
        a = xv * 23170;
        b = yv * 23170;
        v[0] = a + b + wd;  v[1] = -a + b - wd;
        v[2] = -a + b + wd; v[3] = a + b - wd;
      end else if (base_r == BaseMec) begin
        v[0] = (yv + xv + wv) * 32768; v[1] = (yv - xv - wv) * 32768;
        v[2] = (yv - xv + wv) * 32768; v[3] = (yv + xv - wv) * 32768;
      end else begin
        v[2] = xv * 32768 + wd;
        v[0] = yv * 28378 - xv * 16384 + wd;
        v[1] = yv * 28378 + xv * 16384 - wd;
      end
    end else if (base_r == BaseOmni4) begin
      a = project(xv, yv, AngFl4A, it.hd[15:0]);
      b = project(xv, yv, AngFl4B, it.hd[15:0]);
      v[0] = a + wd - fb; v[1] = b - wd + fb;
      v[2] = b + wd - fb; v[3] = a - wd + fb;
    end else begin
      v[2] = project(xv, yv, AngTh3A, it.hd[15:0]) + wd - fb;
      v[0] = project(xv, yv, AngTh3B, it.hd[15:0]) + wd - fb;
      v[1] = project(xv, yv, AngTh3C, it.hd[15:0]) - wd + fb;
    end
    r.cmd = CMD_SET;
    for (int i = 0; i < 4; i++) begin
      r.wheel[i] = 16'(sat_q88((v[i] + 64'sd536870912) >>> 30));
    end
    return r;
  endfunction

  // sender: items from the pending queue, prediction at acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) wheel_due_q.push_back(mix_sample(cur_sample));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_q.size() > 0 && (quiet || $urandom_range(99) >= 32)) begin
          cur_sample = sample_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {1'b0, cur_sample};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (wheel_due_q.size() == 0) begin
          $error("result with nothing expected: %h", m_axis_tdata);
          errors++;
        end else begin
          wheels_t w;
          w = wheel_due_q.pop_front();
          if (m_axis_tdata[1:0] !== w.cmd) begin
            $error("command: expected %0d, got %0d", w.cmd, m_axis_tdata[1:0]);
            errors++;
          end
          for (int i = 0; i < 4; i++) begin
            if (m_axis_tdata[2+16*i +: 16] !== w.wheel[i]) begin
              $error("wheel_%0d: expected %0d, got %0d", i + 1, $signed(w.wheel[i]),
                     $signed(m_axis_tdata[2+16*i +: 16]));
              errors++;
            end
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_cnt = HoldCycles;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 32);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("holonomic_drive_wheel_mixer_tb: errors");
      $finish;
    end
  end

  task automatic write_reg(reg_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_DRIVE_MODE:  mode_r = val[1:0];
      REG_BASE_TYPE:   base_r = val[1:0];
      REG_FACING:      face_r = val[1:0];
      REG_SPEED_SCALE: speed_r = val;
      REG_TURN_RATIO:  turn_r = val;
      REG_HEAD_TOL:    tol_r = val[14:0];
      default:         gain_r = val;
    endcase
  endtask

  task automatic wait_idle();
    wait (sample_q.size() == 0 && !s_axis_tvalid && wheel_due_q.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_stick();
    int k;
    k = $urandom_range(99);
    if (k < 10) return 16'd0;
    if (k < 15) return $urandom_range(1) ? 16'sd32767 : -16'sd32767;
    return 16'($signed($urandom_range(65534)) - 32767);
  endfunction

  function automatic sample_t rand_sample();
    sample_t it;
    it.sx = rand_stick();
    it.sy = rand_stick();
    // triggers idle often so heading hold leaves and enters turns
    if ($urandom_range(99) < 45) begin
      it.tr = '0;
      it.tl = '0;
    end else begin
      it.tr = $urandom_range(3) == 0 ? 15'd0 : 15'($urandom_range(32767));
      it.tl = $urandom_range(3) == 0 ? 15'd0 : 15'($urandom_range(32767));
    end
    if ($urandom_range(99) < 8) begin
      it.sx = '0;
      it.sy = '0;
      it.tr = '0;
      it.tl = '0;
    end
    if ($urandom_range(99) < 20) last_hd = longint'($signed($urandom()));
    else last_hd = longint'($signed(32'(last_hd + $urandom_range(2000) - 1000)));
    it.hd = 32'(last_hd);
    it.busy = $urandom_range(1);
    return it;
  endfunction

  // mode, base, facing, speed, turn ratio, tolerance, gain per phase
  logic [15:0] phase_set [NumPhases][7] = '{
    '{0, 0, 0, 768, 8192, 364, 13834},
    '{0, 1, 3, 65535, 65535, 0, 0},
    '{0, 2, 1, 0, 0, 16384, 65535},
    '{1, 0, 1, 768, 8192, 364, 13834},
    '{1, 2, 2, 65535, 65535, 0, 65535},
    '{1, 1, 3, 512, 4096, 100, 1000},
    '{2, 0, 0, 768, 8192, 364, 13834},
    '{2, 2, 2, 1024, 16384, 0, 65535},
    '{2, 1, 0, 768, 8192, 364, 13834},
    '{3, 0, 2, 300, 20000, 5000, 30000},
    '{1, 3, 0, 768, 8192, 364, 13834},
    '{2, 0, 1, 65535, 0, 16384, 0}
  };

  initial begin
    sample_t it;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_DRIVE_MODE;
    cfg_data_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < NumPhases; p++) begin
      for (int r = 0; r < 7; r++) write_reg(reg_e'(r), phase_set[p][r]);
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      quiet = (p == 3);
      if (p < 6) begin
        // all-zero command, busy and not, then full-scale corners
        it = '0;
        it.busy = 1'b1;
        sample_q.push_back(it);
        it.busy = 1'b0;
        it.hd = 32'h1234_5678;
        sample_q.push_back(it);
        it = '{busy: 1'b1, hd: 32'h7FFF_FFFF, tl: 15'd0, tr: 15'h7FFF,
               sy: -16'sd32767, sx: 16'sd32767};
        sample_q.push_back(it);
        it = '{busy: 1'b0, hd: 32'h8000_0000, tl: 15'h7FFF, tr: 15'd0,
               sy: 16'sd32767, sx: -16'sd32767};
        sample_q.push_back(it);
      end
      for (int n = 0; n < RandPerPhase; n++) begin
        sample_q.push_back(rand_sample());
        if (p == 5 && n == 10) hold_req++;
        if (p == 7 && n == RandPerPhase / 2) begin
          wait (sample_q.size() == 0 && !s_axis_tvalid && wheel_due_q.size() == 0);
        end
      end
      wait_idle();
    end
    if (errors == 0) begin
      $display("holonomic_drive_wheel_mixer_tb: clean");
    end else begin
      $display("holonomic_drive_wheel_mixer_tb: errors");
    end
    $finish;
  end

endmodule
